// ===== src/min_tracking_stack_top_assert.svh =====
// Assertion macros for the min tracking stack.
// Both sample on clk and are disabled while rst_n is low.
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// Same-cycle implication.
`define MTS_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("min tracking stack: same-cycle check failed");

// Next-cycle implication.
`define MTS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("min tracking stack: next-cycle check failed");

`endif

// ===== src/mts_pkg.sv =====
package mts_pkg;

    // action codes
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } rsp_item_t;

    // shift control shared by every cell
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== src/mts_cell.sv =====
module mts_cell
    import mts_pkg::*;
#(
    parameter int WORD_WIDTH = 32
)
(
    input  logic                         clk,
    input  cell_ctrl_t                   ctrl,
    input  logic signed [WORD_WIDTH-1:0] above_word,
    input  logic signed [WORD_WIDTH-1:0] above_min,
    input  logic signed [WORD_WIDTH-1:0] below_word,
    input  logic signed [WORD_WIDTH-1:0] below_min,
    output logic signed [WORD_WIDTH-1:0] word,
    output logic signed [WORD_WIDTH-1:0] run_min
);

    logic signed [WORD_WIDTH-1:0] word_reg;
    logic signed [WORD_WIDTH-1:0] min_reg;
    logic signed [WORD_WIDTH-1:0] word_next;
    logic signed [WORD_WIDTH-1:0] min_next;

    // push moves entries away from the top, pop towards it
    always_comb
    begin
        word_next = word_reg;
        min_next  = min_reg;
        if (ctrl.push)
        begin
            word_next = above_word;
            min_next  = above_min;
        end
        else if (ctrl.pop)
        begin
            word_next = below_word;
            min_next  = below_min;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        min_reg  <= min_next;
    end

    assign word    = word_reg;
    assign run_min = min_reg;

endmodule

// ===== src/mts_out_buf.sv =====
module mts_out_buf
    import mts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  rsp_item_t load_item,
    output logic      full,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_data
);

    logic      out_valid_reg;
    logic      out_valid_next;
    rsp_item_t out_reg;
    rsp_item_t out_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    rsp_item_t skid_reg;
    rsp_item_t skid_next;
    logic      take;

    assign take = out_valid_reg && !rsp_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = load_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = load_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ===== src/min_tracking_stack_top.sv =====
// Channel | Direction | Handshake              | Payload
// cmd     | in        | cmd_valid / cmd_stall  | cmd_item_t: action, value
// rsp     | out       | rsp_valid / rsp_stall  | rsp_item_t: popped, top, min, count, empty, status
//
// Flow: one item a cycle while cmd_stall is low; a push or pop that does not over- or underflow
//   shifts the cell row when accepted, and each result is registered in the output buffer for rsp.
// The two-slot output buffer sets the rate: cmd_stall rises only when both
//   slots hold results that rsp has not taken, so rsp stalls back up through it.
// Reset: rst_n clears the fill count and the output buffer; cell contents are
//   not cleared, as only filled cells are ever read.
module min_tracking_stack_top
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // cell row: index 0 is the top of the stack
    logic signed [WORD_WIDTH-1:0] cell_word [STACK_DEPTH];
    logic signed [WORD_WIDTH-1:0] cell_min  [STACK_DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                         cmd_acc;
    logic                         stack_empty;
    logic                         stack_full;
    cell_ctrl_t                   ctrl;
    logic signed [WORD_WIDTH-1:0] new_word;
    logic signed [WORD_WIDTH-1:0] new_min;
    logic [1:0]                   status;
    logic signed [31:0]           popped;
    logic signed [31:0]           top_after;
    logic signed [31:0]           min_after;
    rsp_item_t                    result;
    logic                         buf_full;

    assign cmd_stall   = buf_full;
    assign cmd_acc     = cmd_valid && !cmd_stall;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));

    // incoming word wrapped to the stored width; running min against the
    // entry below it
    assign new_word = WORD_WIDTH'(cmd_data.value);
    assign new_min  = (!stack_empty && (cell_min[0] < new_word)) ? cell_min[0] : new_word;

    // action decode
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        status     = ST_OK;
        popped     = '0;
        if (cmd_acc)
        begin
            unique case (cmd_data.action)
                ACT_PUSH:
                begin
                    if (stack_full)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_POP:
                begin
                    if (stack_empty)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - CW'(1);
                        popped     = 32'(cell_word[0]);
                    end
                end
                ACT_QUERY:
                begin
                    status = ST_OK;
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    // top and minimum as they stand after the step
    always_comb
    begin
        top_after = '0;
        min_after = '0;
        if (ctrl.push)
        begin
            top_after = 32'(new_word);
            min_after = 32'(new_min);
        end
        else if (ctrl.pop)
        begin
            if (count_reg > CW'(1))
            begin
                top_after = 32'(cell_word[1]);
                min_after = 32'(cell_min[1]);
            end
        end
        else if (!stack_empty)
        begin
            top_after = 32'(cell_word[0]);
            min_after = 32'(cell_min[0]);
        end
    end

    always_comb
    begin
        result.popped_value = popped;
        result.top_value    = top_after;
        result.min_value    = min_after;
        result.entry_count  = 7'(count_next);
        result.is_empty     = (count_next == '0);
        result.status       = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // the cell row: each cell takes from its upper neighbour on push and
    // from its lower neighbour on pop; the bottom cell keeps itself on pop
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic signed [WORD_WIDTH-1:0] above_word;
        logic signed [WORD_WIDTH-1:0] above_min;
        logic signed [WORD_WIDTH-1:0] below_word;
        logic signed [WORD_WIDTH-1:0] below_min;

        if (i == 0)
        begin : g_top
            assign above_word = new_word;
            assign above_min  = new_min;
        end
        else
        begin : g_mid
            assign above_word = cell_word[i-1];
            assign above_min  = cell_min[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below_word = cell_word[i];
            assign below_min  = cell_min[i];
        end
        else
        begin : g_inner
            assign below_word = cell_word[i+1];
            assign below_min  = cell_min[i+1];
        end

        mts_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .above_word (above_word),
            .above_min  (above_min),
            .below_word (below_word),
            .below_min  (below_min),
            .word       (cell_word[i]),
            .run_min    (cell_min[i])
        );
    end

    mts_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd_acc),
        .load_item (result),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // checks
`include "min_tracking_stack_top_assert.svh"

    `MTS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `MTS_ASSERT_NOW(a_min_not_above_top, !stack_empty, !(cell_min[0] > cell_word[0]))
    `MTS_ASSERT_NEXT(a_pop_shrinks, ctrl.pop, count_reg == $past(count_reg) - CW'(1))
    `MTS_ASSERT_NOW(a_stall_has_result, cmd_stall, rsp_valid)

endmodule

// ===== tb/sv/min_stack_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the stack and checks every result.
module min_stack_checker
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  cmd_item_t cmd_data,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp_data,
    output int        fail_count,
    output int        outstanding
);

    logic signed [31:0] stack_words [STACK_DEPTH];
    logic signed [31:0] stack_mins  [STACK_DEPTH];
    int                 stack_fill;
    rsp_item_t          awaited_results [$];
    int                 fault_total;

    // One step of the stack: update the shadow copy, return the result item.
    function automatic rsp_item_t stack_step(input cmd_item_t cmd);
        rsp_item_t          res;
        logic signed [31:0] run_min;
        res        = '0;
        res.status = ST_OK;
        if (cmd.action == ACT_PUSH)
        begin
            if (stack_fill >= STACK_DEPTH)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                run_min = cmd.value;
                if (stack_fill > 0 && stack_mins[stack_fill - 1] < cmd.value)
                    run_min = stack_mins[stack_fill - 1];
                stack_words[stack_fill] = cmd.value;
                stack_mins[stack_fill]  = run_min;
                stack_fill++;
            end
        end
        else if (cmd.action == ACT_POP)
        begin
            if (stack_fill == 0)
            begin
                res.status = ST_UNDERFLOW;
            end
            else
            begin
                stack_fill--;
                res.popped_value = stack_words[stack_fill];
            end
        end
        // query and the spare code leave everything alone
        if (stack_fill > 0)
        begin
            res.top_value = stack_words[stack_fill - 1];
            res.min_value = stack_mins[stack_fill - 1];
        end
        res.entry_count = 7'(stack_fill);
        res.is_empty    = (stack_fill == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        if (!rst_n)
        begin
            stack_fill  = 0;
            fault_total = 0;
            awaited_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // command first, so a same-edge result still finds its entry
            if (cmd_valid && !cmd_stall)
                awaited_results.push_back(stack_step(cmd_data));
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (fault_total < 10)
                        $display("unexpected result: count=%0d status=%0d",
                                 rsp_data.entry_count, rsp_data.status);
                    fault_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want !== rsp_data)
                    begin
                        if (fault_total < 10)
                        begin
                            $display("mismatch exp: pop=%0d top=%0d min=%0d cnt=%0d emp=%0b st=%0d",
                                     want.popped_value, want.top_value, want.min_value,
                                     want.entry_count, want.is_empty, want.status);
                            $display("         got: pop=%0d top=%0d min=%0d cnt=%0d emp=%0b st=%0d",
                                     rsp_data.popped_value, rsp_data.top_value,
                                     rsp_data.min_value, rsp_data.entry_count,
                                     rsp_data.is_empty, rsp_data.status);
                        end
                        fault_total++;
                    end
                end
            end
            fail_count  <= fault_total;
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the min tracking stack; all checking lives in the checker.
module testbench;
    import mts_pkg::*;

    localparam int         STACK_DEPTH    = 64;
    localparam int         RANDOM_ITEMS   = 500;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         SQUEEZE_AT     = 400;   // earliest cycle at which the long hold-off may start
    localparam int         SQUEEZE_CYCLES = 300;
    localparam logic [1:0] ACT_SPARE      = 2'd3;  // unused code, behaves as a query

    // shape of a random segment
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_data;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp_data;

    int        fail_count;
    int        outstanding;
    int        cycle_count;
    bit        tight;       // set for segments with no sender idling

    min_tracking_stack_top #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    min_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_data    (cmd_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Idle cycles before an item: mostly none or a few, now and then a long pause.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tight || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Words lean on the extremes and on a narrow band so equal minima turn up.
    function automatic logic signed [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'sh8000_0000;
        if (r == 1)
            return 32'sh7FFF_FFFF;
        if (r < 4)
            return $signed(32'($urandom_range(0, 15))) - 32'sd8;
        return $signed($urandom);
    endfunction

    function automatic logic [1:0] pick_action(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (r < 92) ? ACT_PUSH : ((r < 96) ? ACT_QUERY : ACT_POP);
            MIX_DRAIN: return (r < 92) ? ACT_POP : ((r < 96) ? ACT_QUERY : ACT_PUSH);
            default:
            begin
                if (r < 45)
                    return ACT_PUSH;
                if (r < 80)
                    return ACT_POP;
                if (r < 95)
                    return ACT_QUERY;
                return ACT_SPARE;
            end
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Valid stays high
    // across back-to-back items, so no edge ever sees it lowered and raised.
    task automatic send_item(input logic [1:0] action, input logic signed [31:0] value);
        int        gap;
        cmd_item_t item;
        item.action = action;
        item.value  = value;
        gap         = idle_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // Receiver: alternating free and stalled stretches. Once, well into the
    // run, it holds off long enough for the output buffer to fill and for
    // cmd_stall to push back on the sender.
    initial
    begin : rsp_side
        int   span;
        logic hold_on;
        bit   squeezed;
        hold_on  = 1'b0;
        squeezed = 1'b0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold_on = !hold_on;
            if (hold_on && !squeezed && cycle_count >= SQUEEZE_AT)
            begin
                span     = SQUEEZE_CYCLES;
                squeezed = 1'b1;
            end
            else if (hold_on)
            begin
                span = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 2) :
                       (($urandom_range(0, 99) < 85) ? $urandom_range(3, 8)
                                                      : $urandom_range(20, 60));
            end
            else
            begin
                // the occasional long free stretch gives runs with no stalls
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
            end
            rsp_stall <= hold_on;
            repeat (span) @(posedge clk);
        end
    end

    // Sender: reset, directed corner items, random segments, then drain and verdict.
    initial
    begin : cmd_side
        int   sent;
        int   seg;
        int   seg_len;
        mix_t mix;
        tight       = 1'b0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stack, underflow, spare code, word extremes,
        // minimum restored after pops, equal minima.
        send_item(ACT_QUERY, 32'sh0000_0000);
        send_item(ACT_POP,   32'shFFFF_FFFF);     // underflow on empty
        send_item(ACT_SPARE, 32'sh1234_5678);     // spare code on empty
        send_item(ACT_PUSH,  32'sh7FFF_FFFF);
        send_item(ACT_PUSH,  32'sh0000_0000);
        send_item(ACT_PUSH,  32'shFFFF_FFFF);
        send_item(ACT_PUSH,  32'sh8000_0000);
        send_item(ACT_QUERY, 32'shFFFF_FFFF);
        send_item(ACT_PUSH,  32'sh0000_0005);
        send_item(ACT_SPARE, 32'shFFFF_FFFF);
        send_item(ACT_POP,   32'sh0000_0000);
        send_item(ACT_POP,   32'sh0000_0000);     // most negative leaves, min back to -1
        send_item(ACT_PUSH,  32'shFFFF_FFFF);     // ties the running minimum
        send_item(ACT_POP,   32'sh7FFF_FFFF);
        send_item(ACT_POP,   32'sh0000_0000);
        send_item(ACT_POP,   32'sh0000_0000);
        send_item(ACT_POP,   32'sh0000_0000);     // back to empty
        send_item(ACT_POP,   32'sh8000_0000);     // underflow again
        send_item(ACT_PUSH,  32'sh8000_0000);
        send_item(ACT_PUSH,  32'sh7FFF_FFFF);
        send_item(ACT_POP,   32'sh0000_0000);
        send_item(ACT_POP,   32'sh0000_0000);

        // Random: the first segment fills past the top (overflow), the second
        // drains past the bottom (underflow), the rest are mostly mixed.
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg == 0)
                mix = MIX_FILL;
            else if (seg == 1)
                mix = MIX_DRAIN;
            else
                mix = ($urandom_range(0, 9) < 2) ? MIX_FILL :
                      (($urandom_range(0, 9) < 2) ? MIX_DRAIN : MIX_ANY);
            seg_len = (mix == MIX_ANY) ? $urandom_range(10, 40) : $urandom_range(75, 90);
            tight   = ($urandom_range(0, 3) == 0);
            repeat (seg_len)
            begin
                send_item(pick_action(mix), pick_word());
                sent++;
            end
            seg++;
        end
        cmd_valid <= 1'b0;

        // outstanding is registered, so let it catch up before trusting it
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== min_tracking_stack_top.f =====
+incdir+src
src/mts_pkg.sv
src/mts_cell.sv
src/mts_out_buf.sv
src/min_tracking_stack_top.sv
tb/sv/min_stack_checker.sv
tb/sv/testbench.sv
